/* rtl/srcc_pkg.sv */
// ----------------------------------------------------------------------------
// srcc_pkg
// Shared constants and types for the slot reservation conflict checker.
// ----------------------------------------------------------------------------
package srcc_pkg;

  localparam int unsigned TIME_SLOTS = 65536;
  localparam int unsigned SLOT_W     = 17;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned LO_W       = $clog2(WORD_W);
  localparam int unsigned ROWS       = (TIME_SLOTS + WORD_W - 1) / WORD_W;
  localparam int unsigned ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned HOR_W      = (TIME_SLOTS > 1) ? $clog2(TIME_SLOTS) + 1 : 1;
  localparam int unsigned POS_W      = ((HOR_W > SLOT_W) ? HOR_W : SLOT_W) + 2;

  localparam logic [POS_W-1:0] TS_POS   = POS_W'(TIME_SLOTS);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_ONCE   = 2'd1,
    MODE_REPEAT = 2'd2
  } mode_e;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WIN   = 5'b00100,
    S_CHK   = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

endpackage

/* rtl/srcc_ram.sv */
// ----------------------------------------------------------------------------
// srcc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module srcc_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/slot_reservation_conflict_check_top.sv */
// ----------------------------------------------------------------------------
// slot_reservation_conflict_check_top
// Time slot bitmap with sticky conflict detection, held in a word-wide RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item: mode, window
//   start, window end (exclusive) and repeat period. Output channel
//   (out_valid_o / out_ready_i) returns one item per input item: the sticky
//   conflict flag.
//   The map lives in a RAM of 64-slot rows. Each touched row is read in the
//   window step, then checked and written back in the check step. Items
//   that change nothing (flag already set, unused mode) go straight from
//   idle to the result; an empty window only passes the window step.
//   A clear item sweeps the whole RAM, one row per cycle.
//   After reset the same sweep runs with in_ready_o low.
//   The result sits in an output register: the next item is accepted while
//   it waits; a finished item then holds until the receiver takes the
//   waiting result.
// ----------------------------------------------------------------------------
module slot_reservation_conflict_check_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  mode_i,
  input  logic [srcc_pkg::SLOT_W-1:0] start_slot_i,
  input  logic [srcc_pkg::SLOT_W-1:0] end_slot_i,
  input  logic [srcc_pkg::SLOT_W-1:0] repeat_period_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        conflict_o
);

  import srcc_pkg::*;

  state_e             state_q, state_d;
  logic [ROW_W-1:0]   clr_q, clr_d;
  logic               clr_reply_q, clr_reply_d;
  logic               flag_q, flag_d;
  logic               once_q, once_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]   win_q, win_d;
  logic [POS_W-1:0]   end_q, end_d;
  logic [SLOT_W-1:0]  period_q, period_d;
  logic               out_valid_q, out_valid_d;
  logic               out_conflict_q, out_conflict_d;

  logic               ram_we, ram_re;
  logic [ROW_W-1:0]   ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  logic [POS_W-1:0]   row_base, row_end, seg_end, seg_diff;
  logic [LO_W:0]      seg_len;
  logic [WORD_W:0]    mask_wide;
  logic [WORD_W-1:0]  mask;
  logic               hit;

  srcc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS),
    .ADDR_W(ROW_W)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Segment of the current window that falls in the current row.
  always_comb begin
    row_base = {pos_q[POS_W-1:LO_W], {LO_W{1'b0}}};
    row_end  = row_base + POS_W'(WORD_W);
    seg_end  = end_q;
    if (TS_POS < seg_end) begin
      seg_end = TS_POS;
    end
    if (row_end < seg_end) begin
      seg_end = row_end;
    end
    seg_diff  = seg_end - pos_q;
    seg_len   = seg_diff[LO_W:0];
    mask_wide = ((WORD_W + 1)'(1) << seg_len) - (WORD_W + 1)'(1);
    mask      = mask_wide[WORD_W-1:0] << pos_q[LO_W-1:0];
    hit       = (ram_rdata & mask) != '0;
  end

  always_comb begin
    state_d        = state_q;
    clr_d          = clr_q;
    clr_reply_d    = clr_reply_q;
    flag_d         = flag_q;
    once_d         = once_q;
    pos_d          = pos_q;
    win_d          = win_q;
    end_d          = end_q;
    period_d       = period_q;
    out_valid_d    = out_valid_q;
    out_conflict_d = out_conflict_q;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = pos_q[LO_W +: ROW_W];
    ram_raddr      = pos_q[LO_W +: ROW_W];
    ram_wdata      = ram_rdata | mask;
    in_ready_o     = (state_q == S_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + ROW_W'(1);
        if (clr_q == ROW_LAST) begin
          clr_d   = '0;
          state_d = clr_reply_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          pos_d    = POS_W'(start_slot_i);
          win_d    = POS_W'(start_slot_i);
          end_d    = POS_W'(end_slot_i);
          period_d = repeat_period_i;
          once_d   = (mode_i == MODE_ONCE) || (repeat_period_i == '0) ||
                     (end_slot_i <= start_slot_i);
          case (mode_e'(mode_i))
            MODE_CLEAR: begin
              flag_d      = 1'b0;
              clr_reply_d = 1'b1;
              state_d     = S_CLEAR;
            end
            MODE_ONCE, MODE_REPEAT: begin
              state_d = flag_q ? S_DONE : S_WIN;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_WIN: begin
        if ((pos_q < end_q) && (pos_q < TS_POS)) begin
          ram_re  = 1'b1;
          state_d = S_CHK;
        end else if (once_q || (end_q > TS_POS)) begin
          state_d = S_DONE;
        end else begin
          // advance the window by one period
          win_d = win_q + POS_W'(period_q);
          pos_d = win_q + POS_W'(period_q);
          end_d = end_q + POS_W'(period_q);
        end
      end
      S_CHK: begin
        if (hit) begin
          // the map no longer matters until the next clear: drop the write
          flag_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          ram_we  = 1'b1;
          pos_d   = seg_end;
          state_d = S_WIN;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d    = 1'b1;
          out_conflict_d = flag_q;
          clr_reply_d    = 1'b0;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      clr_reply_q <= 1'b0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_reply_q <= clr_reply_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    once_q         <= once_d;
    pos_q          <= pos_d;
    win_q          <= win_d;
    end_q          <= end_d;
    period_q       <= period_d;
    out_conflict_q <= out_conflict_d;
  end

  assign out_valid_o = out_valid_q;
  assign conflict_o  = out_conflict_q;

  // The flag only rises on a hit found in the check step.
  a_flag_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(flag_q) |-> $past(state_q == S_CHK))
    else $error("conflict flag set outside the check step");

  // The flag only falls on an accepted clear item.
  a_flag_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(flag_q) |-> $past(in_valid_i && in_ready_o && (mode_i == MODE_CLEAR)))
    else $error("conflict flag cleared without a clear item");

  // A check step always covers at least one slot below the horizon.
  a_chk_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> ((mask != '0) && (pos_q < TS_POS)))
    else $error("empty or out-of-range segment in check step");

  // RAM writes happen only in the sweep or the write-back step.
  a_ram_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == S_CLEAR) || (state_q == S_CHK)))
    else $error("unexpected map write");

endmodule
